### hdl/crog_pkg.sv
// ----------------------------------------------------------------------------
// crog_pkg
// Shared constants of the circle ring offset generator.
// ----------------------------------------------------------------------------
`default_nettype none

package crog_pkg;

	// Default width of the radius and of the row index.
	localparam int unsigned RADIUS_BITS_DEF   = 10;

	// Value of the radius register after reset.
	localparam int unsigned RING_RADIUS_RESET = 1;

	// Eight-way symmetry gives at most this many points for one row.
	localparam int unsigned POINTS_PER_ROW    = 8;

endpackage

`default_nettype wire

### hdl/crog_square.sv
// ----------------------------------------------------------------------------
// crog_square
// Front of the pipeline: takes a row request, squares radius and row, and
// forms n = r*r - y*y over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module crog_square #(
	parameter int unsigned RB = crog_pkg::RADIUS_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [RB-1:0]     row_index,
	input  logic [RB-1:0]     ring_radius,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [RB-1:0]     y_out,
	output logic [2*RB-1:0]   n_out,
	output logic              skip_out
);

	localparam int unsigned NW = 2 * RB;

	logic          valid_s1, valid_s2, valid_s3;
	logic [RB-1:0] y_s1, r_s1, y_s2, y_s3;
	logic          skip_s1, skip_s2, skip_s3;
	logic [NW-1:0] yy_s2, rr_s2, n_s3;
	logic          adv1, adv2, adv3;

	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			y_s1    <= row_index;
			r_s1    <= ring_radius;
			// A row at or beyond the radius gives no points.
			skip_s1 <= (row_index >= ring_radius);
		end
		if (adv2 && valid_s1) begin
			y_s2    <= y_s1;
			skip_s2 <= skip_s1;
			yy_s2   <= NW'(y_s1) * NW'(y_s1);
			rr_s2   <= NW'(r_s1) * NW'(r_s1);
		end
		if (adv3 && valid_s2) begin
			y_s3    <= y_s2;
			skip_s3 <= skip_s2;
			n_s3    <= rr_s2 - yy_s2;
		end
	end

	assign out_valid = valid_s3;
	assign y_out     = y_s3;
	assign n_out     = n_s3;
	assign skip_out  = skip_s3;

endmodule

`default_nettype wire

### hdl/crog_root_step.sv
// ----------------------------------------------------------------------------
// crog_root_step
// One register stage of the integer square root: settles one bit of the root
// and keeps the remainder n - s*s up to date.
// ----------------------------------------------------------------------------
`default_nettype none

module crog_root_step #(
	parameter int unsigned RB  = crog_pkg::RADIUS_BITS_DEF,
	parameter int unsigned BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [RB-1:0]     y_in,
	input  logic              skip_in,
	input  logic [2*RB-1:0]   rem_in,
	input  logic [RB-1:0]     root_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [RB-1:0]     y_out,
	output logic              skip_out,
	output logic [2*RB-1:0]   rem_out,
	output logic [RB-1:0]     root_out
);

	localparam int unsigned NW = 2 * RB;
	localparam int unsigned TW = NW + 1;

	logic          valid_q;
	logic          adv;
	logic [TW-1:0] trial;
	logic          take;
	logic [RB-1:0] y_q, root_q;
	logic          skip_q;
	logic [NW-1:0] rem_q;

	assign adv      = !valid_q || !out_stall;
	assign in_stall = !adv;

	// Setting this bit adds 2^(BIT+1)*s + 2^(2*BIT) to the square of the root.
	assign trial = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
	assign take  = (TW'(rem_in) >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			y_q    <= y_in;
			skip_q <= skip_in;
			if (take) begin
				rem_q  <= rem_in - trial[NW-1:0];
				root_q <= root_in | (RB'(1) << BIT);
			end else begin
				rem_q  <= rem_in;
				root_q <= root_in;
			end
		end
	end

	assign out_valid = valid_q;
	assign y_out     = y_q;
	assign skip_out  = skip_q;
	assign rem_out   = rem_q;
	assign root_out  = root_q;

endmodule

`default_nettype wire

### hdl/crog_expand.sv
// ----------------------------------------------------------------------------
// crog_expand
// Rounds the root to x, builds the set of symmetric points of the row and
// sends them out one a cycle, while out_stall is low, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crog_expand #(
	parameter int unsigned RB = crog_pkg::RADIUS_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [RB-1:0]       y_in,
	input  logic                skip_in,
	input  logic [2*RB-1:0]     rem_in,
	input  logic [RB-1:0]       root_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [RB:0]  offset_x,
	output logic signed [RB:0]  offset_y,
	output logic                last_point
);

	import crog_pkg::*;

	localparam int unsigned NW = 2 * RB;
	localparam int unsigned OW = RB + 1;
	localparam int unsigned PW = POINTS_PER_ROW;
	localparam int unsigned KW = $clog2(PW);

	logic [OW-1:0] x_wide;
	logic [RB-1:0] x_new;
	logic          xnz, ynz, diag, keep;
	logic [PW-1:0] mask_new, mask_q, mask_after;
	logic [RB-1:0] x_q, y_q;
	logic [KW-1:0] k;
	logic          out_free, emit, row_free, load;
	logic [RB-1:0] mag_x, mag_y;
	logic [OW-1:0] ext_x, ext_y, val_x, val_y;
	logic          out_valid_q, last_q;
	logic [OW-1:0] ox_q, oy_q;

	// Round to nearest: the root goes up by one when the remainder exceeds it.
	assign x_wide = {1'b0, root_in} + OW'(rem_in > NW'(root_in));
	// For a row below the radius the rounded root never exceeds the radius, so it fits the radius width.
	assign x_new  = x_wide[RB-1:0];

	assign xnz  = (x_new != '0);
	assign ynz  = (y_in != '0);
	assign diag = (x_new != y_in);
	assign keep = !skip_in && (OW'(y_in) <= x_wide);

	// One bit per candidate point, in output order.
	always_comb begin
		mask_new = '0;
		if (keep) begin
			mask_new[0] = 1'b1;
			mask_new[1] = ynz;
			mask_new[2] = xnz;
			mask_new[3] = xnz && ynz;
			mask_new[4] = diag;
			mask_new[5] = diag && xnz;
			mask_new[6] = diag && ynz;
			mask_new[7] = diag && xnz && ynz;
		end
	end

	always_comb begin
		k = '0;
		for (int i = PW - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				k = KW'(i);
			end
		end
	end

	assign mask_after = mask_q & ~(PW'(1) << k);
	assign out_free   = !out_valid_q || !out_stall;
	assign emit       = (mask_q != '0) && out_free;
	assign row_free   = (mask_q == '0) || (emit && (mask_after == '0));
	assign load       = in_valid && row_free;
	assign in_stall   = !row_free;

	// The upper half of the points swaps the roles of x and y.
	assign mag_x = k[2] ? y_q : x_q;
	assign mag_y = k[2] ? x_q : y_q;
	assign ext_x = {1'b0, mag_x};
	assign ext_y = {1'b0, mag_y};
	assign val_x = k[1] ? (OW'(0) - ext_x) : ext_x;
	assign val_y = k[0] ? (OW'(0) - ext_y) : ext_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= mask_new;
			end else if (emit) begin
				mask_q <= mask_after;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x_new;
			y_q <= y_in;
		end
		if (emit) begin
			ox_q   <= val_x;
			oy_q   <= val_y;
			last_q <= (mask_after == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign offset_x   = ox_q;
	assign offset_y   = oy_q;
	assign last_point = last_q;

endmodule

`default_nettype wire

### hdl/circle_ring_offset_generator.sv
// ----------------------------------------------------------------------------
// circle_ring_offset_generator
// Expands one row of the first octant of a circle into its symmetric integer
// offsets, with x = round(sqrt(r*r - y*y)).
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   row       in         row_valid / row_stall     row_index
//   point     out        point_valid / point_stall offset_x, offset_y, last_point
//   radius    in         ring_radius_wr_en         ring_radius_wr_data
//
// A row passes 3 + RADIUS_BITS + 1 register stages before its first point
// reaches the output register (one root bit is settled per stage).
// The single output register sends one point a cycle while point_stall is low,
// up to eight points per row; rows that give no points send none there.
// Reset clears all valid bits and sets the radius to 1.
// A stall holds the output register and backs up through the pipeline;
// empty stages still fill while the output waits.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_ring_offset_generator #(
	parameter int unsigned RADIUS_BITS = crog_pkg::RADIUS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ring_radius_wr_en,
	input  logic [RADIUS_BITS-1:0]      ring_radius_wr_data,
	input  logic                        row_valid,
	output logic                        row_stall,
	input  logic [RADIUS_BITS-1:0]      row_index,
	output logic                        point_valid,
	input  logic                        point_stall,
	output logic signed [RADIUS_BITS:0] offset_x,
	output logic signed [RADIUS_BITS:0] offset_y,
	output logic                        last_point
);

	import crog_pkg::*;

	localparam int unsigned RB = RADIUS_BITS;
	localparam int unsigned NW = 2 * RB;

	logic [RB-1:0] ring_radius_q;

	logic          v_w    [RB+1];
	logic          st_w   [RB+1];
	logic [RB-1:0] y_w    [RB+1];
	logic          skip_w [RB+1];
	logic [NW-1:0] rem_w  [RB+1];
	logic [RB-1:0] root_w [RB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_radius_q <= RB'(RING_RADIUS_RESET);
		end else if (ring_radius_wr_en) begin
			ring_radius_q <= ring_radius_wr_data;
		end
	end

	crog_square #(
		.RB (RB)
	) u_square (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (row_valid),
		.in_stall    (row_stall),
		.row_index   (row_index),
		.ring_radius (ring_radius_q),
		.out_valid   (v_w[0]),
		.out_stall   (st_w[0]),
		.y_out       (y_w[0]),
		.n_out       (rem_w[0]),
		.skip_out    (skip_w[0])
	);

	assign root_w[0] = '0;

	// Root bits are settled from the most significant one down.
	for (genvar i = 0; i < RB; i++) begin : g_root
		crog_root_step #(
			.RB  (RB),
			.BIT (RB - 1 - i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_w[i]),
			.in_stall  (st_w[i]),
			.y_in      (y_w[i]),
			.skip_in   (skip_w[i]),
			.rem_in    (rem_w[i]),
			.root_in   (root_w[i]),
			.out_valid (v_w[i+1]),
			.out_stall (st_w[i+1]),
			.y_out     (y_w[i+1]),
			.skip_out  (skip_w[i+1]),
			.rem_out   (rem_w[i+1]),
			.root_out  (root_w[i+1])
		);
	end

	crog_expand #(
		.RB (RB)
	) u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_w[RB]),
		.in_stall   (st_w[RB]),
		.y_in       (y_w[RB]),
		.skip_in    (skip_w[RB]),
		.rem_in     (rem_w[RB]),
		.root_in    (root_w[RB]),
		.out_valid  (point_valid),
		.out_stall  (point_stall),
		.offset_x   (offset_x),
		.offset_y   (offset_y),
		.last_point (last_point)
	);

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the circle ring offset generator. Rows are sent through the
// row channel under several radius settings and idling patterns, and every
// point that comes out is checked against a prediction of the symmetric
// offsets of that row, taken in the order in which the rows were accepted.
// ----------------------------------------------------------------------------

module tb;

	localparam int unsigned RB            = crog_pkg::RADIUS_BITS_DEF;
	localparam int unsigned ROW_MAX       = (1 << RB) - 1;
	localparam int          SETTLE_CYCLES = 2 * (RB + 5);
	localparam int          HOLD_CYCLES   = 300;
	localparam int          QUIET_LIMIT   = 3000;

	typedef struct packed {
		logic signed [RB:0] x;
		logic signed [RB:0] y;
		logic               last;
	} ring_point_t;

	logic                 clk                 = 1'b0;
	logic                 arst_n              = 1'b0;
	logic                 ring_radius_wr_en   = 1'b0;
	logic [RB-1:0]        ring_radius_wr_data = '0;
	logic                 row_valid           = 1'b0;
	logic                 row_stall;
	logic [RB-1:0]        row_index           = '0;
	logic                 point_valid;
	logic                 point_stall         = 1'b0;
	logic signed [RB:0]   offset_x;
	logic signed [RB:0]   offset_y;
	logic                 last_point;

	logic [RB-1:0]        rows_to_send[$];
	ring_point_t          points_due[$];
	int unsigned          radius_now    = crog_pkg::RING_RADIUS_RESET;
	int                   rows_queued   = 0;
	int                   rows_accepted = 0;
	int                   mismatches    = 0;
	int                   quiet_cycles  = 0;
	int                   send_idle_pct = 0;
	int                   stall_pct     = 0;
	int                   hold_req      = 0;
	int                   hold_seen     = 0;
	int                   hold_left     = 0;
	logic                 row_taken     = 1'b0;

	circle_ring_offset_generator #(
		.RADIUS_BITS(RB)
	) DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.ring_radius_wr_en  (ring_radius_wr_en),
		.ring_radius_wr_data(ring_radius_wr_data),
		.row_valid          (row_valid),
		.row_stall          (row_stall),
		.row_index          (row_index),
		.point_valid        (point_valid),
		.point_stall        (point_stall),
		.offset_x           (offset_x),
		.offset_y           (offset_y),
		.last_point         (last_point)
	);

	always #5 clk = ~clk;

	// Floor of the square root, settled one bit at a time from the top.
	function automatic int unsigned root_floor(input int unsigned n);
		int unsigned root;
		int unsigned trial;
		root = 0;
		for (int b = RB; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (trial * trial <= n) begin
				root = trial;
			end
		end
		return root;
	endfunction

	// Appends the points that one accepted row should produce, in output order.
	function automatic void expand_row(input logic [RB-1:0] row);
		int unsigned        y;
		int unsigned        n;
		int unsigned        s;
		int unsigned        x;
		int                 k;
		logic signed [RB:0] sx;
		logic signed [RB:0] sy;
		logic signed [RB:0] px[8];
		logic signed [RB:0] py[8];
		ring_point_t        p;
		y = int'(row);
		if (y >= radius_now) begin
			return;
		end
		n = radius_now * radius_now - y * y;
		s = root_floor(n);
		x = s + ((n - s * s > s) ? 1 : 0);
		if (y > x) begin
			return;
		end
		sx = (RB+1)'(x);
		sy = (RB+1)'(y);
		k  = 0;
		px[k] = sx; py[k] = sy; k++;
		if (y != 0) begin
			px[k] = sx; py[k] = -sy; k++;
		end
		if (x != 0) begin
			px[k] = -sx; py[k] = sy; k++;
		end
		if (x != 0 && y != 0) begin
			px[k] = -sx; py[k] = -sy; k++;
		end
		// On the diagonal the swapped half would only repeat the points above.
		if (x != y) begin
			px[k] = sy; py[k] = sx; k++;
			if (x != 0) begin
				px[k] = sy; py[k] = -sx; k++;
			end
			if (y != 0) begin
				px[k] = -sy; py[k] = sx; k++;
			end
			if (x != 0 && y != 0) begin
				px[k] = -sy; py[k] = -sx; k++;
			end
		end
		for (int i = 0; i < k; i++) begin
			p.x    = px[i];
			p.y    = py[i];
			p.last = (i == k - 1);
			points_due.push_back(p);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	// Row driver: a new request is placed only once the previous one has gone.
	always @(negedge clk) begin
		if (!row_valid || row_taken) begin
			if (rows_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				row_valid <= 1'b1;
				row_index <= rows_to_send.pop_front();
			end else begin
				row_valid <= 1'b0;
			end
		end
	end

	// Point receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen   <= hold_req;
			hold_left   <= HOLD_CYCLES;
			point_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left   <= hold_left - 1;
			point_stall <= 1'b1;
		end else begin
			point_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Monitor, checker and watchdog.
	always @(posedge clk) begin
		ring_point_t want;
		logic        row_acc;
		logic        point_acc;
		row_acc   = arst_n && row_valid && !row_stall;
		point_acc = arst_n && point_valid && !point_stall;
		row_taken <= row_acc;
		if (row_acc) begin
			expand_row(row_index);
			rows_accepted++;
		end
		if (point_acc) begin
			if (points_due.size() == 0) begin
				report_mismatch("point with nothing pending, offset_x", int'(offset_x), 0);
			end else begin
				want = points_due.pop_front();
				if (offset_x !== want.x) begin
					report_mismatch("offset_x", int'(offset_x), int'(want.x));
				end
				if (offset_y !== want.y) begin
					report_mismatch("offset_y", int'(offset_y), int'(want.y));
				end
				if (last_point !== want.last) begin
					report_mismatch("last_point", int'(last_point), int'(want.last));
				end
			end
		end
		if (row_acc || point_acc) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_row(input int unsigned row);
		rows_to_send.push_back(RB'(row));
		rows_queued++;
	endtask

	// Mostly rows inside the radius, the rest anywhere in the field's range.
	task automatic queue_random_rows(input int count);
		for (int i = 0; i < count; i++) begin
			if (radius_now > 0 && $urandom_range(0, 9) < 8) begin
				queue_row($urandom_range(0, radius_now - 1));
			end else begin
				queue_row($urandom_range(0, ROW_MAX));
			end
		end
	endtask

	// Rows that give no points may still be in the pipeline after the last
	// point, hence the extra cycles before anything else is changed.
	task automatic drain();
		while (rows_accepted != rows_queued || points_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_radius(input int unsigned value);
		@(negedge clk);
		ring_radius_wr_en   <= 1'b1;
		ring_radius_wr_data <= RB'(value);
		@(negedge clk);
		ring_radius_wr_en   <= 1'b0;
		radius_now = value;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Radius left at its reset value.
		queue_row(0);
		queue_row(1);
		queue_row(ROW_MAX);
		drain();

		// Zero radius: nothing lies below it.
		set_radius(0);
		queue_row(0);
		queue_row(ROW_MAX);
		queue_row(512);
		drain();

		// Radius 7: row 5 lands on the diagonal, row 6 lies past it.
		set_radius(7);
		queue_row(5);
		queue_row(0);
		queue_row(6);
		queue_row(3);
		drain();

		// Largest radius: widest offsets, and rows either side of the diagonal.
		set_radius(ROW_MAX);
		queue_row(0);
		queue_row(ROW_MAX - 1);
		queue_row(723);
		queue_row(724);
		queue_row(1);
		queue_row(511);
		queue_row(ROW_MAX);
		drain();

		send_idle_pct = 0;
		stall_pct     = 0;
		queue_random_rows(15);
		drain();

		set_radius($urandom_range(3, ROW_MAX));
		send_idle_pct = 53;
		stall_pct     = 0;
		queue_random_rows(15);
		drain();

		set_radius(12);
		send_idle_pct = 0;
		stall_pct     = 53;
		queue_random_rows(15);
		drain();

		set_radius(300);
		send_idle_pct = 9;
		stall_pct     = 9;
		queue_random_rows(15);
		drain();

		// The receiver holds off while rows keep coming, so the block backs up.
		set_radius(100);
		send_idle_pct = 0;
		stall_pct     = 0;
		queue_random_rows(25);
		hold_req++;
		drain();

		if (points_due.size() != 0) begin
			report_mismatch("points left over", points_due.size(), 0);
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
